// ===== hdl/cmd_pkg.sv =====
package cmd_pkg;

    localparam int PENDING_DEPTH = 8;
    localparam int CNT_W         = $clog2(PENDING_DEPTH + 1);
    localparam int LEVEL_W       = 4;
    localparam int IN_DATA_W     = 144;
    localparam int IN_USER_W     = 2;
    localparam int OUT_DATA_W    = 152;
    localparam int OUT_USER_W    = 2;

    localparam logic [15:0] RX_FLAG_MASK = 16'h8000;

    typedef enum logic [1:0] {
        OP_ARM     = 2'd0,
        OP_DELIVER = 2'd1,
        OP_CLEAR   = 2'd2,
        OP_ABORT   = 2'd3
    } t_op;

    typedef struct packed {
        logic [63:0] param_b;
        logic [31:0] param_a;
        logic [31:0] status;
        logic [15:0] code;
    } t_entry;

    typedef struct packed {
        logic hit_en;
        logic arm;
        logic shift_all;
        logic load;
        logic live;
    } t_cell_ctl;

    typedef struct packed {
        logic               unused_pad;
        logic [LEVEL_W-1:0] pending_level;
        logic               now_waiting;
        logic               aborted;
        logic               dropped_oldest;
        t_entry             reply;
    } t_result_data;

endpackage

// ===== hdl/cmd_cell.sv =====
module cmd_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cmd_pkg::t_cell_ctl i_ctl,
    input  logic [15:0]        i_key_code,
    input  logic [31:0]        i_key_param,
    input  cmd_pkg::t_entry    i_next,
    input  cmd_pkg::t_entry    i_item,
    input  logic               i_found,
    output logic               o_found,
    output logic               o_take,
    output cmd_pkg::t_entry    o_entry
);
    import cmd_pkg::*;

    t_entry r_entry;
    logic   r_hit;
    logic   n_hit;

    assign n_hit = ((r_entry.code & ~RX_FLAG_MASK) == i_key_code)
                   && (r_entry.param_a == i_key_param);

    assign o_take  = i_ctl.live && r_hit && !i_found;
    assign o_found = i_found || o_take;
    assign o_entry = r_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else if (i_ctl.hit_en) begin
            r_hit <= n_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_entry <= i_item;
        end else if (i_ctl.shift_all || (i_ctl.arm && o_found)) begin
            r_entry <= i_next;
        end
    end

endmodule

// ===== hdl/completion_match_demux_unit.sv =====
// Completion match demultiplexer.
// Input stream (s_axis): tuser carries the operation (arm, deliver, clear,
// abort), tdata the message: code, status, first and second parameter.
// Output stream (m_axis): exactly one beat per input beat, in order. tdata
// carries the reply message and the status flags, tuser marks a valid reply
// and whether it came from the pending queue.
// Pending completions sit in a row of cells, oldest in cell 0. An arm beat
// loads each cell's match bit against the new expectation in the accept
// cycle; the execute state then finds the oldest hit through the chain, hands
// it out and shifts the younger cells down by one.
// The result is registered in the execute state that follows acceptance. A
// beat is taken only in the idle state, so no new beat is accepted until the
// last one has passed through the execute state.
// A stalled receiver holds the result register; one more input beat is still
// taken and then waits in the execute state until the register frees.
// Reset empties the queue and clears the expectation and the waiting flag;
// queue contents are not cleared.
module completion_match_demux_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // code[15:0], status[47:16], param_a[79:48], param_b[143:80]
    input  logic [cmd_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    // cmd[1:0]
    input  logic [cmd_pkg::IN_USER_W-1:0]  i_s_axis_tuser,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // reply_code[15:0], reply_status[47:16], reply_param_a[79:48],
    // reply_param_b[143:80], dropped_oldest[144], aborted[145],
    // now_waiting[146], pending_level[150:147], zero[151]
    output logic [cmd_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    // reply_valid[0], from_pending[1]
    output logic [cmd_pkg::OUT_USER_W-1:0] o_m_axis_tuser
);
    import cmd_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state       r_state, n_state;
    t_op          r_op;
    t_entry       r_item;
    logic [15:0]  r_exp_code;
    logic [31:0]  r_exp_param;
    logic         r_wait, n_wait;
    logic [CNT_W-1:0] r_count, n_count;
    logic         r_out_valid;
    t_result_data r_out_data, n_out_data;
    logic         r_out_reply_valid, n_out_reply_valid;
    logic         r_out_from_pending, n_out_from_pending;

    logic   w_s_fire;
    logic   w_exec;
    logic   w_deliver_match;
    logic   w_full;
    logic   w_push;
    t_entry w_in_entry;
    t_entry w_sel;

    t_cell_ctl w_ctl   [PENDING_DEPTH];
    t_entry    w_entry [PENDING_DEPTH];
    logic      w_found [PENDING_DEPTH+1];
    logic [PENDING_DEPTH-1:0] w_take;

    assign w_in_entry      = t_entry'(i_s_axis_tdata);
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_s_fire        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_exec          = (r_state == S_EXEC) && (!r_out_valid || i_m_axis_tready);

    assign w_deliver_match = r_wait
                             && ((r_item.code & ~RX_FLAG_MASK) == r_exp_code)
                             && (r_item.param_a == r_exp_param);
    assign w_full          = (r_count == CNT_W'(PENDING_DEPTH));
    assign w_push          = w_exec && (r_op == OP_DELIVER) && !w_deliver_match;

    assign w_found[0] = 1'b0;

    for (genvar g = 0; g < PENDING_DEPTH; g++) begin : g_cell
        t_entry w_next;

        if (g == PENDING_DEPTH - 1) begin : g_last
            assign w_next = r_item;
        end else begin : g_mid
            assign w_next = w_entry[g+1];
        end

        assign w_ctl[g].hit_en    = w_s_fire && (t_op'(i_s_axis_tuser) == OP_ARM);
        assign w_ctl[g].arm       = w_exec && (r_op == OP_ARM);
        assign w_ctl[g].shift_all = w_push && w_full;
        assign w_ctl[g].load      = w_push && (w_full ? (g == PENDING_DEPTH - 1)
                                                      : (r_count == CNT_W'(g)));
        assign w_ctl[g].live      = (r_count > CNT_W'(g));

        cmd_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl[g]),
            .i_key_code  (w_in_entry.code),
            .i_key_param (w_in_entry.param_a),
            .i_next      (w_next),
            .i_item      (r_item),
            .i_found     (w_found[g]),
            .o_found     (w_found[g+1]),
            .o_take      (w_take[g]),
            .o_entry     (w_entry[g])
        );
    end

    always_comb begin
        w_sel = '0;
        for (int i = 0; i < PENDING_DEPTH; i++) begin
            if (w_take[i]) begin
                w_sel = w_sel | w_entry[i];
            end
        end
    end

    always_comb begin
        n_state            = r_state;
        n_wait             = r_wait;
        n_count            = r_count;
        n_out_data         = '0;
        n_out_reply_valid  = 1'b0;
        n_out_from_pending = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_s_fire) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_exec) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        unique case (r_op)
            OP_ARM: begin
                if (w_found[PENDING_DEPTH]) begin
                    n_out_reply_valid  = 1'b1;
                    n_out_from_pending = 1'b1;
                    n_out_data.reply   = w_sel;
                    n_count            = r_count - CNT_W'(1);
                    n_wait             = 1'b0;
                end else begin
                    n_wait = 1'b1;
                end
            end
            OP_DELIVER: begin
                if (w_deliver_match) begin
                    n_out_reply_valid = 1'b1;
                    n_out_data.reply  = r_item;
                    n_wait            = 1'b0;
                end else if (w_full) begin
                    n_out_data.dropped_oldest = 1'b1;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            OP_CLEAR: begin
                n_count = '0;
            end
            OP_ABORT: begin
                n_out_data.aborted = r_wait;
                n_wait             = 1'b0;
                n_count            = '0;
            end
            default: n_count = r_count;
        endcase
        n_out_data.now_waiting   = n_wait;
        n_out_data.pending_level = LEVEL_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wait      <= 1'b0;
            r_count     <= '0;
            r_exp_code  <= '0;
            r_exp_param <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_s_fire && (t_op'(i_s_axis_tuser) == OP_ARM)) begin
                r_exp_code  <= w_in_entry.code;
                r_exp_param <= w_in_entry.param_a;
            end
            if (w_exec) begin
                r_wait      <= n_wait;
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_fire) begin
            r_op   <= t_op'(i_s_axis_tuser);
            r_item <= w_in_entry;
        end
        if (w_exec) begin
            r_out_data         <= n_out_data;
            r_out_reply_valid  <= n_out_reply_valid;
            r_out_from_pending <= n_out_from_pending;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = {r_out_from_pending, r_out_reply_valid};

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(PENDING_DEPTH))
        else $error("pending count above depth");

    a_take_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_take))
        else $error("more than one cell selected");

    a_arm_hit_pops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_exec && (r_op == OP_ARM) && w_found[PENDING_DEPTH])
        |=> (r_count == $past(r_count) - CNT_W'(1)) && !r_wait)
        else $error("arm hit did not pop one entry");

    a_abort_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data.aborted)
        |-> (!r_out_reply_valid && !r_out_data.now_waiting
             && (r_out_data.pending_level == '0)))
        else $error("abort result inconsistent");

endmodule
